// ===== rtl/core/bfa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the best-fit block allocator: field widths, codes, sequencer
// states and the result struct. No dependencies.
package bfa_pkg;

  localparam int unsigned MaxBlocksDef = 16;
  localparam int unsigned SizeBitsDef  = 16;

  localparam int unsigned SizeFieldW = 16;
  localparam int unsigned IdxFieldW  = 4;
  localparam int unsigned LeftFieldW = 16;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_REFUSED = 2'd1,
    ST_LOADED  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e               status;
    logic [IdxFieldW-1:0]  block_index;
    logic [LeftFieldW-1:0] leftover;
  } res_t;

  typedef struct packed {
    logic fits;
    logic better;
    logic zero;
  } fit_t;

endpackage

// ===== rtl/core/bfa_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the allocator's input and result streams.
// Depends on bfa_pkg.
interface bfa_in_if import bfa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [SizeFieldW-1:0] size;

  modport source (output valid, command, size, input ready);
  modport sink   (input valid, command, size, output ready);
endinterface

interface bfa_out_if import bfa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [IdxFieldW-1:0]  block_index;
  logic [LeftFieldW-1:0] leftover;

  modport source (output valid, status, block_index, leftover, input ready);
  modport sink   (input valid, status, block_index, leftover, output ready);
endinterface

// ===== rtl/core/bfa_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/bfa_fit_unit.sv =====
`timescale 1ns / 1ps
// Shared compare/subtract unit: candidate vs request and vs current best.
// Depends on bfa_pkg.
module bfa_fit_unit import bfa_pkg::*; #(
  parameter int unsigned SizeBits = SizeBitsDef
) (
  input  logic [SizeBits-1:0] cand_i,
  input  logic [SizeBits-1:0] req_i,
  input  logic [SizeBits-1:0] best_i,
  input  logic                found_i,
  output logic [SizeBits-1:0] diff_o,
  output fit_t                fit_o
);

  logic [SizeBits:0] sub;

  assign sub          = {1'b0, cand_i} - {1'b0, req_i};
  assign diff_o       = sub[SizeBits-1:0];
  assign fit_o.fits   = ~sub[SizeBits];
  assign fit_o.better = ~found_i | (cand_i < best_i);
  assign fit_o.zero   = (sub[SizeBits-1:0] == '0);

endmodule

// ===== rtl/core/best_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// Best-fit block allocator top level: sequencer, block table and result register.
// Allocate: the result is set by the size RAM scan at one entry per cycle (S_SCAN),
// then S_DRAIN, S_WRITE and S_DONE; a new request is accepted only back in S_IDLE.
// Load: S_LOAD then S_DONE.
// Reset (async, active low) clears live bits, load count and control; sizes are
// not cleared. Depends on bfa_pkg, bfa_if, bfa_ram, bfa_fit_unit.
module best_fit_block_allocator import bfa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDef,
  parameter int unsigned SIZE_BITS  = SizeBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bfa_in_if.sink           in_ch_i,
  bfa_out_if.source        out_ch_o
);

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  state_e state_q, state_d;

  logic [SIZE_BITS-1:0] req_q;
  logic [IdxW-1:0]      scan_q;
  logic                 pend_v_q;
  logic [IdxW-1:0]      pend_idx_q;
  logic                 found_q;
  logic [IdxW-1:0]      best_idx_q;
  logic [SIZE_BITS-1:0] best_size_q;
  logic [MAX_BLOCKS-1:0] live_q;
  logic [CntW-1:0]      loaded_q;
  res_t                 res_q;
  res_t                 out_q;
  logic                 out_v_q;

  logic                 in_acc;
  logic                 out_free;
  logic                 full;
  logic                 scan_last;
  logic                 eval;
  logic                 take;

  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic [SIZE_BITS-1:0] cand;
  logic [SIZE_BITS-1:0] diff;
  fit_t                 fit;

  logic [SIZE_BITS+SizeFieldW-1:0] size_ext;
  logic [SIZE_BITS+LeftFieldW-1:0] diff_ext;
  logic [SIZE_BITS+LeftFieldW-1:0] req_ext;
  logic [IdxW+IdxFieldW-1:0]       best_ext;
  logic [CntW+IdxFieldW-1:0]       cnt_ext;

  assign size_ext = {{SIZE_BITS{1'b0}}, in_ch_i.size};
  assign diff_ext = {{LeftFieldW{1'b0}}, diff};
  assign req_ext  = {{LeftFieldW{1'b0}}, req_q};
  assign best_ext = {{IdxFieldW{1'b0}}, best_idx_q};
  assign cnt_ext  = {{IdxFieldW{1'b0}}, loaded_q};

  assign in_ch_i.ready = (state_q == S_IDLE);
  assign in_acc        = in_ch_i.valid & in_ch_i.ready;
  assign out_free      = ~out_v_q | out_ch_o.ready;
  assign full          = (loaded_q == CntW'(MAX_BLOCKS));
  assign scan_last     = (scan_q == IdxW'(MAX_BLOCKS - 1));
  assign take          = eval & live_q[pend_idx_q] & fit.fits & fit.better;

  bfa_ram #(
    .Width (SIZE_BITS),
    .Depth (MAX_BLOCKS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  bfa_fit_unit #(
    .SizeBits (SIZE_BITS)
  ) u_fit (
    .cand_i  (cand),
    .req_i   (req_q),
    .best_i  (best_size_q),
    .found_i (found_q),
    .diff_o  (diff),
    .fit_o   (fit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (in_ch_i.command == CMD_ALLOC) ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD:  state_d = S_DONE;
      S_SCAN: begin
        if (scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_WRITE;
      S_WRITE: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx_q;
    ram_wdata = diff;
    cand      = ram_rdata;
    eval      = 1'b0;
    case (state_q)
      S_LOAD: begin
        ram_we    = ~full;
        ram_waddr = loaded_q[IdxW-1:0];
        ram_wdata = req_q;
      end
      S_SCAN:  eval = pend_v_q;
      S_DRAIN: eval = 1'b1;
      S_WRITE: begin
        cand   = best_size_q;
        ram_we = found_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      live_q   <= '0;
      loaded_q <= '0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && out_ch_o.ready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          pend_v_q <= 1'b0;
          found_q  <= 1'b0;
        end
        S_LOAD: begin
          if (!full) begin
            live_q[loaded_q[IdxW-1:0]] <= 1'b1;
            loaded_q                   <= loaded_q + CntW'(1);
          end
        end
        S_SCAN: begin
          pend_v_q <= 1'b1;
          if (take) begin
            found_q <= 1'b1;
          end
        end
        S_DRAIN: begin
          if (take) begin
            found_q <= 1'b1;
          end
        end
        S_WRITE: begin
          if (found_q && fit.zero) begin
            live_q[best_idx_q] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        req_q  <= size_ext[SIZE_BITS-1:0];
        scan_q <= '0;
      end
      S_LOAD: begin
        if (full) begin
          res_q <= '{status: ST_FULL, block_index: '0, leftover: '0};
        end else begin
          res_q <= '{status: ST_LOADED, block_index: cnt_ext[IdxFieldW-1:0],
                     leftover: req_ext[LeftFieldW-1:0]};
        end
      end
      S_SCAN, S_DRAIN: begin
        if (state_q == S_SCAN) begin
          pend_idx_q <= scan_q;
          if (!scan_last) begin
            scan_q <= scan_q + IdxW'(1);
          end
        end
        if (take) begin
          best_idx_q  <= pend_idx_q;
          best_size_q <= ram_rdata;
        end
      end
      S_WRITE: begin
        if (found_q) begin
          res_q <= '{status: ST_GRANTED, block_index: best_ext[IdxFieldW-1:0],
                     leftover: diff_ext[LeftFieldW-1:0]};
        end else begin
          res_q <= '{status: ST_REFUSED, block_index: '0, leftover: '0};
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign out_ch_o.valid       = out_v_q;
  assign out_ch_o.status      = out_q.status;
  assign out_ch_o.block_index = out_q.block_index;
  assign out_ch_o.leftover    = out_q.leftover;

`ifndef SYNTHESIS
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= CntW'(MAX_BLOCKS))
    else $error("load count past table size");

  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(live_q) <= 32'(loaded_q))
    else $error("more live blocks than loads");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside done state");

  a_alloc_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_ch_i.command == CMD_ALLOC |=> state_q == S_SCAN && scan_q == '0)
    else $error("allocate did not start scan at entry zero");

  a_grant_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE && found_q |-> live_q[best_idx_q] && fit.fits)
    else $error("grant on dead or undersized block");
`endif

endmodule
